FILE: rtl/lst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types, codes and coil tables of the light seeking stepper tracker.
// ----------------------------------------------------------------------------
package lst_pkg;

    // fixed sizing
    localparam int SAMPLE_BITS = 12;
    localparam int MAX_SWEEP   = 32;
    localparam int DB_BITS     = 12;
    localparam int COUNT_BITS  = 6;
    localparam int INDEX_BITS  = 5;
    localparam int SUM_BITS    = SAMPLE_BITS + 1;
    localparam int CFG_BITS    = 12;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [SUM_BITS-1:0]    t_sum;
    typedef logic [DB_BITS-1:0]     t_deadband;
    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [INDEX_BITS-1:0]  t_index;
    typedef logic [3:0]             t_coil;
    typedef logic [1:0]             t_phase;
    typedef logic [1:0]             t_step;
    typedef logic [1:0]             t_mode_code;
    typedef logic [0:0]             t_cfg_index;
    typedef logic [CFG_BITS-1:0]    t_cfg_data;

    // register indexes
    localparam t_cfg_index REG_DEADBAND    = 1'd0;
    localparam t_cfg_index REG_SWEEP_STEPS = 1'd1;

    // register reset values
    localparam t_deadband DEADBAND_RESET = 12'd150;
    localparam t_count    SWEEP_RESET    = 6'd20;

    // step codes
    localparam t_step STEP_NONE = 2'd0;
    localparam t_step STEP_FWD  = 2'd1;
    localparam t_step STEP_BWD  = 2'd2;

    // mode codes as reported
    localparam t_mode_code MODE_SWEEP  = 2'd0;
    localparam t_mode_code MODE_RETURN = 2'd1;
    localparam t_mode_code MODE_TRACK  = 2'd2;

    // configuration as seen by the core
    typedef struct packed {
        t_deadband deadband;
        t_count    sweep_steps;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_coil      coil_pattern;
        t_step      step_taken;
        t_mode_code mode_now;
        t_index     best_index;
    } t_result;

    // coil pattern for a forward step from a given phase
    function automatic t_coil fwd_pattern(input t_phase ph);
        t_coil pat;
        unique case (ph)
            2'd0:    pat = 4'd6;
            2'd1:    pat = 4'd3;
            2'd2:    pat = 4'd9;
            default: pat = 4'd12;
        endcase
        return pat;
    endfunction

    // coil pattern for a backward step from a given phase
    function automatic t_coil bwd_pattern(input t_phase ph);
        t_coil pat;
        unique case (ph)
            2'd0:    pat = 4'd9;
            2'd1:    pat = 4'd12;
            2'd2:    pat = 4'd6;
            default: pat = 4'd3;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lst_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lst_sample_if
// Valid/ready channel carrying one pair of light sensor samples.
// ----------------------------------------------------------------------------
interface lst_sample_if;
    import lst_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_a;
    t_sample sample_b;

    modport source (output valid, output sample_a, output sample_b, input ready);
    modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface
`default_nettype wire

FILE: rtl/lst_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lst_result_if
// Valid/ready channel carrying one stepper result item.
// ----------------------------------------------------------------------------
interface lst_result_if;
    import lst_pkg::*;

    logic       valid;
    logic       ready;
    t_coil      coil_pattern;
    t_step      step_taken;
    t_mode_code mode_now;
    t_index     best_index;

    modport source (
        output valid, output coil_pattern, output step_taken,
        output mode_now, output best_index, input ready
    );
    modport sink (
        input valid, input coil_pattern, input step_taken,
        input mode_now, input best_index, output ready
    );
endinterface
`default_nettype wire

FILE: rtl/lst_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lst_cfg_regs
// Deadband and sweep length registers behind a plain write port.
// ----------------------------------------------------------------------------
module lst_cfg_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire lst_pkg::t_cfg_index i_cfg_index,
    input  wire lst_pkg::t_cfg_data  i_cfg_wdata,
    output lst_pkg::t_cfg            o_cfg
);
    import lst_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband    <= DEADBAND_RESET;
            r_cfg.sweep_steps <= SWEEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEADBAND:    r_cfg.deadband    <= i_cfg_wdata[DB_BITS-1:0];
                REG_SWEEP_STEPS: r_cfg.sweep_steps <= i_cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

FILE: rtl/lst_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lst_core
// Sweep, return and track state with the one-step next-state logic.
// ----------------------------------------------------------------------------
module lst_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire lst_pkg::t_sample i_sample_a,
    input  wire lst_pkg::t_sample i_sample_b,
    input  wire lst_pkg::t_cfg    i_cfg,
    output lst_pkg::t_result      o_result
);
    import lst_pkg::*;

    typedef enum logic [1:0] {
        SWEEP  = 2'd0,
        RETURN = 2'd1,
        TRACK  = 2'd2
    } t_mode;

    t_mode  r_mode,  n_mode;
    t_phase r_phase, n_phase;
    t_count r_count, n_count;
    t_sum   r_least, n_least;
    t_index r_index, n_index;
    t_count r_back,  n_back;
    t_coil  r_coil,  n_coil;

    t_count    len;
    t_count    count_inc;
    t_count    back_dec;
    t_sum      sum;
    t_sample   diff;
    logic      do_fwd;
    logic      do_bwd;
    t_step     taken;
    t_mode_code mode_code;

    // clamp sweep length to 1..MAX_SWEEP
    always_comb begin
        if (i_cfg.sweep_steps == '0) begin
            len = COUNT_BITS'(1);
        end else if (i_cfg.sweep_steps > COUNT_BITS'(MAX_SWEEP)) begin
            len = COUNT_BITS'(MAX_SWEEP);
        end else begin
            len = i_cfg.sweep_steps;
        end
    end

    assign sum       = SUM_BITS'(i_sample_a) + SUM_BITS'(i_sample_b);
    assign diff      = (i_sample_a > i_sample_b) ? (i_sample_a - i_sample_b)
                                                 : (i_sample_b - i_sample_a);
    assign count_inc = r_count + COUNT_BITS'(1);
    assign back_dec  = (r_back != '0) ? (r_back - COUNT_BITS'(1)) : '0;

    // mode decision
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_least = r_least;
        n_index = r_index;
        n_back  = r_back;
        do_fwd  = 1'b0;
        do_bwd  = 1'b0;
        unique case (r_mode)
            SWEEP: begin
                // first sample seeds the minimum, later ones replace on strictly less
                if (r_count == '0) begin
                    n_least = sum;
                    n_index = '0;
                end else if (sum < r_least) begin
                    n_least = sum;
                    n_index = r_count[INDEX_BITS-1:0];
                end
                do_fwd  = 1'b1;
                n_count = count_inc;
                if (count_inc >= len) begin
                    // best position past a shortened sweep takes one step back
                    n_back = (COUNT_BITS'(n_index) < len) ? (len - COUNT_BITS'(n_index))
                                                         : COUNT_BITS'(1);
                    n_mode = RETURN;
                end
            end
            RETURN: begin
                do_bwd = 1'b1;
                n_back = back_dec;
                if (back_dec == '0) begin
                    n_mode = TRACK;
                end
            end
            default: begin
                // track toward the brighter sensor outside the deadband
                if (diff >= i_cfg.deadband) begin
                    if (i_sample_a > i_sample_b) begin
                        do_fwd = 1'b1;
                    end else if (i_sample_a < i_sample_b) begin
                        do_bwd = 1'b1;
                    end
                end
                n_mode = TRACK;
            end
        endcase
    end

    // coil drive and phase
    always_comb begin
        n_coil  = r_coil;
        n_phase = r_phase;
        taken   = STEP_NONE;
        if (do_fwd) begin
            n_coil  = fwd_pattern(r_phase);
            n_phase = r_phase + 2'd1;
            taken   = STEP_FWD;
        end else if (do_bwd) begin
            n_coil  = bwd_pattern(r_phase);
            n_phase = r_phase - 2'd1;
            taken   = STEP_BWD;
        end
    end

    // reported mode code
    always_comb begin
        unique case (n_mode)
            SWEEP:   mode_code = MODE_SWEEP;
            RETURN:  mode_code = MODE_RETURN;
            default: mode_code = MODE_TRACK;
        endcase
    end

    // state update on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= SWEEP;
            r_phase <= '0;
            r_count <= '0;
            r_least <= '0;
            r_index <= '0;
            r_back  <= '0;
            r_coil  <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_count <= n_count;
            r_least <= n_least;
            r_index <= n_index;
            r_back  <= n_back;
            r_coil  <= n_coil;
        end
    end

    assign o_result.coil_pattern = n_coil;
    assign o_result.step_taken   = taken;
    assign o_result.mode_now     = mode_code;
    assign o_result.best_index   = n_index;
endmodule
`default_nettype wire

FILE: rtl/light_seek_stepper_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// light_seek_stepper_tracker
// Light seeking stepper controller: sweep, return to the least-sum sweep
// position, then track toward the brighter of two sensors.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one pair of sensor readings per transfer; o_result
//   returns exactly one item per input: coil pattern, step code, mode after
//   the item and the best sweep index so far.
//   i_cfg_we/i_cfg_index/i_cfg_wdata write deadband (index 0) and
//   sweep_steps (index 1); write only while no item is in flight.
// Pipeline: a transfer accepted on i_sample is loaded into the input
//   register, its result then into the result register, from which it
//   is presented on o_result.
// Throughput: one item per cycle while o_result is not held off; the state
//   update is adds, compares and small counter steps between the registers.
// Stalls: while o_result is held off the result register keeps its item;
//   one more item waits in the input register, then i_sample.ready drops.
// Reset: synchronous active-low; mode returns to sweep, coils off, phase 0,
//   deadband 150 and sweep_steps 20.
// ----------------------------------------------------------------------------
module light_seek_stepper_tracker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    lst_sample_if.sink               i_sample,
    lst_result_if.source             o_result,
    input  wire logic                i_cfg_we,
    input  wire lst_pkg::t_cfg_index i_cfg_index,
    input  wire lst_pkg::t_cfg_data  i_cfg_wdata
);
    import lst_pkg::*;

    logic    r_in_valid;
    t_sample r_a;
    t_sample r_b;
    logic    r_out_valid;
    t_result r_res;

    t_cfg    cfg;
    t_result core_res;
    logic    advance;
    logic    in_ready;

    assign advance  = !r_out_valid || o_result.ready;
    assign in_ready = !r_in_valid || advance;
    assign i_sample.ready = in_ready;

    lst_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lst_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (r_in_valid && advance),
        .i_sample_a (r_a),
        .i_sample_b (r_b),
        .i_cfg      (cfg),
        .o_result   (core_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_sample.valid) begin
            r_a <= i_sample.sample_a;
            r_b <= i_sample.sample_b;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_res <= core_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.coil_pattern = r_res.coil_pattern;
    assign o_result.step_taken   = r_res.step_taken;
    assign o_result.mode_now     = r_res.mode_now;
    assign o_result.best_index   = r_res.best_index;
endmodule
`default_nettype wire
